[src/uart_frame_ring_with_length_queue_defines.svh]
`ifndef UART_FRAME_RING_WITH_LENGTH_QUEUE_DEFINES_SVH
`define UART_FRAME_RING_WITH_LENGTH_QUEUE_DEFINES_SVH
// same-cycle implication, sampled on every rising edge out of reset
`define UFRLQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on every rising edge out of reset
`define UFRLQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[src/ufrlq_pkg.sv]
// ----------------------------------------------------------------------------
// ufrlq_pkg
// sizes, character codes, opcodes and shared types of the frame ring
// ----------------------------------------------------------------------------
package ufrlq_pkg;

  localparam int RING_DEPTH  = 4096;
  localparam int CHUNK_MAX   = 256;
  localparam int QUEUE_DEPTH = 64;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(CHUNK_MAX + 1);
  localparam int STG_AW  = $clog2(CHUNK_MAX);
  localparam int Q_AW    = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W = $clog2(QUEUE_DEPTH + 1);
  // wide enough for ring sums and for chunk lengths
  localparam int CMP_W   = ((CNT_W > RING_AW) ? CNT_W : RING_AW) + 1;

  localparam int             CTR_W   = 16;
  localparam logic [CTR_W-1:0] CTR_MAX = '1;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_IDLE     = 2'd1,
    OP_LINE_ERR = 2'd2,
    OP_READ     = 2'd3
  } opcode_t;

  // one length-queue entry
  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] keep;
    logic             cmd;
  } qentry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lenq_status_t;

  // ring pointer plus a length, wrapped once
  function automatic logic [RING_AW-1:0] ring_add(logic [RING_AW-1:0] a,
                                                  logic [CNT_W-1:0] b);
    logic [CMP_W-1:0] s;
    s = CMP_W'(a) + CMP_W'(b);
    if (s >= CMP_W'(RING_DEPTH)) begin
      s = s - CMP_W'(RING_DEPTH);
    end
    return s[RING_AW-1:0];
  endfunction

endpackage

[src/ufrlq_ram.sv]
// ----------------------------------------------------------------------------
// ufrlq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ufrlq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ufrlq_lenq.sv]
// ----------------------------------------------------------------------------
// ufrlq_lenq
// length queue with the head entry always presented
// ----------------------------------------------------------------------------
module ufrlq_lenq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ufrlq_pkg::qentry_t      push_ent,
  input  logic                    pop,
  output ufrlq_pkg::qentry_t      head_ent,
  output ufrlq_pkg::lenq_status_t status
);

  logic [ufrlq_pkg::Q_AW-1:0]    head, head_next;
  logic [ufrlq_pkg::Q_AW-1:0]    tail, tail_next;
  logic [ufrlq_pkg::QFILL_W-1:0] fill, fill_next;
  logic                          byp_valid;
  ufrlq_pkg::qentry_t            byp_ent;
  logic [$bits(ufrlq_pkg::qentry_t)-1:0] rdata;

  function automatic logic [ufrlq_pkg::Q_AW-1:0] q_inc(logic [ufrlq_pkg::Q_AW-1:0] p);
    return (p == ufrlq_pkg::Q_AW'(ufrlq_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_next = pop  ? q_inc(head) : head;
    tail_next = push ? q_inc(tail) : tail;
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      byp_valid <= 1'b0;
    end else begin
      head      <= head_next;
      tail      <= tail_next;
      fill      <= fill_next;
      // write and read of the same slot: ram returns the old data, so the pushed entry is bypassed
      byp_valid <= push && (tail == head_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_ent <= push_ent;
  end

  ufrlq_ram #(
    .WIDTH($bits(ufrlq_pkg::qentry_t)),
    .DEPTH(ufrlq_pkg::QUEUE_DEPTH)
  ) u_qram (
    .clk  (clk),
    .we   (push),
    .waddr(tail),
    .wdata(push_ent),
    .re   (1'b1),
    .raddr(head_next),
    .rdata(rdata)
  );

  assign head_ent     = byp_valid ? byp_ent : ufrlq_pkg::qentry_t'(rdata);
  assign status.empty = (fill == '0);
  assign status.full  = (fill == ufrlq_pkg::QFILL_W'(ufrlq_pkg::QUEUE_DEPTH));

endmodule

[src/uart_frame_ring_with_length_queue.sv]
// ----------------------------------------------------------------------------
// uart_frame_ring_with_length_queue
// chunks received bytes into frames held in a byte ring plus a length queue
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// in       to block   in_valid / in_ready   opcode, rx_byte_in, line_error_code
// out      from block out_valid / out_ready byte_valid, frame_byte, first_of_frame,
//                                           last_of_frame, frame_is_command,
//                                           byte_kept, three counters, last_error
//
// one transaction in per cycle while in_ready is high; its result passes p1, then the output register
// at most one ring access per transaction: a byte write on receive while its slot is free, a byte read on read
// reset is synchronous; no clearing pass, ring and queue contents start unknown
// a chunk whose bytes met a full ring but that still fits at commit is copied
// from the stage buffer afterwards: input held until the last copied byte is written
// out_ready low stalls the output register, then the input, with nothing lost
//
module uart_frame_ring_with_length_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte_in,
  input  logic [7:0]  line_error_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        byte_valid,
  output logic [7:0]  frame_byte,
  output logic        first_of_frame,
  output logic        last_of_frame,
  output logic        frame_is_command,
  output logic        byte_kept,
  output logic [15:0] ring_drop_count,
  output logic [15:0] queue_drop_count,
  output logic [15:0] error_count,
  output logic [7:0]  last_error
);

`include "uart_frame_ring_with_length_queue_defines.svh"

  localparam int RAW = ufrlq_pkg::RING_AW;
  localparam int CW  = ufrlq_pkg::CNT_W;
  localparam int XW  = ufrlq_pkg::CMP_W;
  localparam int TW  = ufrlq_pkg::CTR_W;

  // result fields apart from the ring byte
  typedef struct packed {
    logic          rd;
    logic          first;
    logic          last;
    logic          cmd;
    logic          kept;
    logic [TW-1:0] rdrop;
    logic [TW-1:0] qdrop;
    logic [TW-1:0] errs;
    logic [7:0]    lerr;
  } meta_t;

  // ring and stage state
  logic [RAW-1:0] wp, wp_next;
  logic [RAW-1:0] base, base_next;
  logic [CW-1:0]  rd_off, rd_off_next;
  logic [CW-1:0]  stage_count, stage_count_next;
  logic [CW-1:0]  stage_keep, stage_keep_next;
  logic [15:0]    stage_first_two, stage_first_two_next;
  // first chunk byte that could not go into the ring on arrival
  logic           skip_seen, skip_seen_next;
  logic [CW-1:0]  skip_idx, skip_idx_next;

  // counters
  logic [TW-1:0]  rdrop_cnt, rdrop_next;
  logic [TW-1:0]  qdrop_cnt, qdrop_next;
  logic [TW-1:0]  err_cnt, err_next;
  logic [7:0]     lerr, lerr_next;

  // backfill copy from stage buffer to ring
  logic           sw_active;
  logic [CW-1:0]  sw_idx;
  logic [CW-1:0]  sw_end;
  logic [RAW-1:0] sw_base;
  logic           sw_wr_pend;
  logic [RAW-1:0] sw_wr_addr;

  // result pipeline
  logic           p1_valid;
  meta_t          p1_meta;
  logic           p1_move;
  meta_t          out_meta;
  logic [7:0]     out_byte;

  // comb
  ufrlq_pkg::opcode_t       op;
  logic                     accept;
  logic [XW-1:0]            used, free;
  logic [CW-1:0]            cnt_inc;
  logic [CW-1:0]            keep_new;
  logic [15:0]              first_two_new;
  logic                     stg_we;
  logic                     ring_stage_ok;
  logic                     ring_we_stg;
  logic                     skip_now;
  logic                     commit_req;
  logic [CW-1:0]            commit_n;
  logic [CW-1:0]            commit_keep;
  logic [15:0]              commit_ft;
  logic                     commit_cmd;
  logic                     ring_short;
  logic                     commit_ok;
  logic                     needs_fill;
  logic [CW-1:0]            fill_from;
  logic                     rd_go;
  logic                     rd_last;
  logic                     rd_kept;
  logic                     rdrop_inc, qdrop_inc, err_inc;
  ufrlq_pkg::qentry_t       push_ent;
  ufrlq_pkg::qentry_t       head_ent;
  ufrlq_pkg::lenq_status_t  q_status;
  logic                     ring_we;
  logic [RAW-1:0]           ring_waddr;
  logic [7:0]               ring_wdata;
  logic [RAW-1:0]           ring_raddr;
  logic [7:0]               ring_rdata;
  logic [7:0]               stg_rdata;

  assign op      = ufrlq_pkg::opcode_t'(opcode);
  assign p1_move = p1_valid && (!out_valid || out_ready);
  // held in reset and during backfill, else whenever the result stage can drain
  assign in_ready = !rst && !sw_active && !sw_wr_pend &&
                    (!p1_valid || !out_valid || out_ready);
  assign accept  = in_valid && in_ready;

  // free ring space, one slot kept spare
  always_comb begin
    if (wp >= base) begin
      used = XW'(wp) - XW'(base);
    end else begin
      used = XW'(wp) + XW'(ufrlq_pkg::RING_DEPTH) - XW'(base);
    end
    free = XW'(ufrlq_pkg::RING_DEPTH - 1) - used;
  end

  always_comb begin
    stage_count_next     = stage_count;
    stage_keep_next      = stage_keep;
    stage_first_two_next = stage_first_two;
    skip_seen_next       = skip_seen;
    skip_idx_next        = skip_idx;
    wp_next              = wp;
    base_next            = base;
    rd_off_next          = rd_off;
    lerr_next            = lerr;
    stg_we               = 1'b0;
    commit_req           = 1'b0;
    rd_go                = 1'b0;
    err_inc              = 1'b0;

    cnt_inc  = stage_count + CW'(1);
    keep_new = ((rx_byte_in != ufrlq_pkg::CH_CR) && (rx_byte_in != ufrlq_pkg::CH_LF))
               ? cnt_inc : stage_keep;
    if (stage_count == '0) begin
      first_two_new = {8'h00, rx_byte_in};
    end else if (stage_count == CW'(1)) begin
      first_two_new = {rx_byte_in, stage_first_two[7:0]};
    end else begin
      first_two_new = stage_first_two;
    end

    if (accept) begin
      unique case (op)
        ufrlq_pkg::OP_RX_BYTE: begin
          stg_we     = 1'b1;
          commit_req = (cnt_inc == CW'(ufrlq_pkg::CHUNK_MAX));
        end
        ufrlq_pkg::OP_IDLE: begin
          commit_req = (stage_count != '0);
        end
        ufrlq_pkg::OP_LINE_ERR: begin
          err_inc   = 1'b1;
          lerr_next = line_error_code;
        end
        ufrlq_pkg::OP_READ: begin
          rd_go = !q_status.empty;
        end
        default: ;
      endcase
    end

    // byte goes straight into the ring slot it will own, while that slot is free
    ring_stage_ok = (XW'(stage_count) < free);
    ring_we_stg   = stg_we && !skip_seen && ring_stage_ok;
    skip_now      = stg_we && !skip_seen && !ring_stage_ok;

    if (stg_we) begin
      stage_count_next     = cnt_inc;
      stage_keep_next      = keep_new;
      stage_first_two_next = first_two_new;
      if (skip_now) begin
        skip_seen_next = 1'b1;
        skip_idx_next  = stage_count;
      end
    end

    commit_n    = stg_we ? cnt_inc : stage_count;
    commit_keep = stg_we ? keep_new : stage_keep;
    commit_ft   = stg_we ? first_two_new : stage_first_two;
    commit_cmd  = (commit_ft[7:0] == ufrlq_pkg::CH_ESC) ||
                  ((commit_n == CW'(2)) && (commit_ft[15:8] == ufrlq_pkg::CH_NUL) &&
                   ((commit_ft[7:0] == ufrlq_pkg::CH_LF) ||
                    (commit_ft[7:0] == ufrlq_pkg::CH_FF)));
    ring_short  = (XW'(commit_n) > free);
    // queue check comes before the ring check
    qdrop_inc   = commit_req && q_status.full;
    rdrop_inc   = commit_req && !q_status.full && ring_short;
    commit_ok   = commit_req && !q_status.full && !ring_short;
    needs_fill  = skip_seen || skip_now;
    fill_from   = skip_seen ? skip_idx : stage_count;

    push_ent.len  = commit_n;
    push_ent.keep = commit_keep;
    push_ent.cmd  = commit_cmd;

    if (commit_ok) begin
      wp_next = ufrlq_pkg::ring_add(wp, commit_n);
    end
    // any end of chunk, or a line error, empties the stage
    if (commit_req || err_inc) begin
      stage_count_next     = '0;
      stage_keep_next      = '0;
      stage_first_two_next = '0;
      skip_seen_next       = 1'b0;
    end

    // read of the next frame byte
    rd_last = ((rd_off + CW'(1)) >= head_ent.len);
    rd_kept = head_ent.cmd || (rd_off < head_ent.keep);
    if (rd_go) begin
      if (rd_last) begin
        base_next   = ufrlq_pkg::ring_add(base, head_ent.len);
        rd_off_next = '0;
      end else begin
        rd_off_next = rd_off + CW'(1);
      end
    end

    // saturating counters
    rdrop_next = (rdrop_inc && (rdrop_cnt != ufrlq_pkg::CTR_MAX)) ? rdrop_cnt + 1'b1
                                                                   : rdrop_cnt;
    qdrop_next = (qdrop_inc && (qdrop_cnt != ufrlq_pkg::CTR_MAX)) ? qdrop_cnt + 1'b1
                                                                   : qdrop_cnt;
    err_next   = (err_inc && (err_cnt != ufrlq_pkg::CTR_MAX)) ? err_cnt + 1'b1 : err_cnt;
  end

  // ring ports: staging and backfill never write in the same cycle
  assign ring_we    = ring_we_stg || sw_wr_pend;
  assign ring_waddr = sw_wr_pend ? sw_wr_addr : ufrlq_pkg::ring_add(wp, stage_count);
  assign ring_wdata = sw_wr_pend ? stg_rdata : rx_byte_in;
  assign ring_raddr = ufrlq_pkg::ring_add(base, rd_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp              <= '0;
      base            <= '0;
      rd_off          <= '0;
      stage_count     <= '0;
      stage_keep      <= '0;
      stage_first_two <= '0;
      skip_seen       <= 1'b0;
      skip_idx        <= '0;
      rdrop_cnt       <= '0;
      qdrop_cnt       <= '0;
      err_cnt         <= '0;
      lerr            <= '0;
      sw_active       <= 1'b0;
      sw_idx          <= '0;
      sw_wr_pend      <= 1'b0;
      p1_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      wp              <= wp_next;
      base            <= base_next;
      rd_off          <= rd_off_next;
      stage_count     <= stage_count_next;
      stage_keep      <= stage_keep_next;
      stage_first_two <= stage_first_two_next;
      skip_seen       <= skip_seen_next;
      skip_idx        <= skip_idx_next;
      rdrop_cnt       <= rdrop_next;
      qdrop_cnt       <= qdrop_next;
      err_cnt         <= err_next;
      lerr            <= lerr_next;

      // backfill: read stage buffer, write ring in the following cycle
      sw_wr_pend <= sw_active;
      if (commit_ok && needs_fill) begin
        sw_active <= 1'b1;
        sw_idx    <= fill_from;
      end else if (sw_active) begin
        sw_idx <= sw_idx + CW'(1);
        if ((sw_idx + CW'(1)) == sw_end) begin
          sw_active <= 1'b0;
        end
      end

      if (accept) begin
        p1_valid <= 1'b1;
      end else if (p1_move) begin
        p1_valid <= 1'b0;
      end

      if (p1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (commit_ok && needs_fill) begin
      sw_end  <= commit_n;
      sw_base <= wp;
    end
    if (sw_active) begin
      sw_wr_addr <= ufrlq_pkg::ring_add(sw_base, sw_idx);
    end
    if (accept) begin
      p1_meta.rd    <= rd_go;
      p1_meta.first <= rd_go && (rd_off == '0);
      p1_meta.last  <= rd_go && rd_last;
      p1_meta.cmd   <= rd_go && head_ent.cmd;
      p1_meta.kept  <= rd_go && rd_kept;
      p1_meta.rdrop <= rdrop_next;
      p1_meta.qdrop <= qdrop_next;
      p1_meta.errs  <= err_next;
      p1_meta.lerr  <= lerr_next;
    end
    if (p1_move) begin
      out_meta <= p1_meta;
      out_byte <= p1_meta.rd ? ring_rdata : 8'h00;
    end
  end

  ufrlq_ram #(
    .WIDTH(8),
    .DEPTH(ufrlq_pkg::RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(ring_waddr),
    .wdata(ring_wdata),
    .re   (rd_go),
    .raddr(ring_raddr),
    .rdata(ring_rdata)
  );

  // copy of the open chunk, only read back for backfill
  ufrlq_ram #(
    .WIDTH(8),
    .DEPTH(ufrlq_pkg::CHUNK_MAX)
  ) u_stage (
    .clk  (clk),
    .we   (stg_we),
    .waddr(stage_count[ufrlq_pkg::STG_AW-1:0]),
    .wdata(rx_byte_in),
    .re   (sw_active),
    .raddr(sw_idx[ufrlq_pkg::STG_AW-1:0]),
    .rdata(stg_rdata)
  );

  ufrlq_lenq u_lenq (
    .clk     (clk),
    .rst     (rst),
    .push    (commit_ok),
    .push_ent(push_ent),
    .pop     (rd_go && rd_last),
    .head_ent(head_ent),
    .status  (q_status)
  );

  assign byte_valid       = out_meta.rd;
  assign frame_byte       = out_byte;
  assign first_of_frame   = out_meta.first;
  assign last_of_frame    = out_meta.last;
  assign frame_is_command = out_meta.cmd;
  assign byte_kept        = out_meta.kept;
  assign ring_drop_count  = out_meta.rdrop;
  assign queue_drop_count = out_meta.qdrop;
  assign error_count      = out_meta.errs;
  assign last_error       = out_meta.lerr;

  // checks
  `UFRLQ_ASSERT_IMPL(a_no_take_in_backfill, sw_active || sw_wr_pend, !in_ready, "transaction taken during backfill")
  `UFRLQ_ASSERT_NEXT(a_backfill_starts, commit_ok && needs_fill, sw_active, "backfill did not start after commit")
  `UFRLQ_ASSERT_IMPL(a_cmd_bytes_kept, out_valid && byte_valid && frame_is_command, byte_kept, "command frame byte marked trimmed")

endmodule
